>>> hdl/jpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the joypad port packet receiver.
// No dependencies; imported by jpr_core and joypad_port_packet_receiver.
package jpr_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Select line patterns as written (bit1 = P15, bit0 = P14)
  localparam logic [1:0] SEL_BOTH_LOW  = 2'b00;
  localparam logic [1:0] SEL_P14_HIGH  = 2'b01;
  localparam logic [1:0] SEL_P14_LOW   = 2'b10;
  localparam logic [1:0] SEL_BOTH_HIGH = 2'b11;

  // Multiplayer request command and player id values
  localparam logic [4:0] CMD_MLT_REQ   = 5'h11;
  localparam logic [3:0] PLAYER_ONE    = 4'hF;
  localparam logic [3:0] PLAYER_FIRST  = 4'hE;
  localparam logic [3:0] PLAYER_WRAP4  = 4'hB;
  localparam logic [3:0] PLAYER_WRAP2  = 4'hD;

  // Read marks: all three seen
  localparam logic [2:0] MARKS_ALL     = 3'b111;
  localparam logic [2:0] MARK_READ     = 3'b100;
  localparam logic [2:0] MARK_P14_LOW  = 3'b010;
  localparam logic [2:0] MARK_P15_LOW  = 3'b001;

  localparam logic [2:0] PKT_CNT_MAX   = 3'd7;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] ADDR_TIMEOUT  = 2'd0;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] select_bits;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] packet_number;
    logic [3:0] byte_number;
    logic       packet_done;
    logic       command_done;
    logic [4:0] command_code;
    logic [3:0] player_id;
    logic       timed_out;
  } out_item_t;

endpackage

>>> hdl/jpr_core.sv
`timescale 1ns / 1ps
// Receiver state and per-item next-state logic; the result is combinational.
// Depends on jpr_pkg.
module jpr_core import jpr_pkg::*; #(
  parameter int PACKET_BITS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  logic [15:0] timeout_ticks,
  output out_item_t  result
);

  localparam int BCW = $clog2(PACKET_BITS + 1);
  localparam logic [BCW-1:0] FULL_BITS = BCW'(PACKET_BITS);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_XFER = 2'd2
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic           pending_r, pending_nxt;
  logic [BCW-1:0] bit_count_r, bit_count_nxt;
  logic [7:0]     shift_r, shift_nxt;
  logic [3:0]     byte_pos_r, byte_pos_nxt;
  logic [2:0]     pkt_cnt_r, pkt_cnt_nxt;
  logic [7:0]     header_r, header_nxt;
  logic [7:0]     first_data_r, first_data_nxt;
  logic [2:0]     marks_r, marks_nxt;
  logic [3:0]     player_r, player_nxt;
  logic           multi_r, multi_nxt;
  logic           four_r, four_nxt;
  logic           first_use_r, first_use_nxt;
  logic [15:0]    timer_r, timer_nxt;

  // Next state and result for one item
  always_comb begin
    logic [3:0] dec;
    logic [4:0] done_code;
    logic       code_set;
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    byte_pos_nxt   = byte_pos_r;
    pkt_cnt_nxt    = pkt_cnt_r;
    header_nxt     = header_r;
    first_data_nxt = first_data_r;
    marks_nxt      = marks_r;
    player_nxt     = player_r;
    multi_nxt      = multi_r;
    four_nxt       = four_r;
    first_use_nxt  = first_use_r;
    timer_nxt      = timer_r;
    result         = '0;
    dec            = player_r - 4'd1;
    done_code      = header_r[7:3];
    code_set       = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        if (timer_r != 16'd0) begin
          timer_nxt = timer_r - 16'd1;
          if (timer_r == 16'd1) begin
            phase_nxt        = PH_IDLE;
            result.timed_out = 1'b1;
          end
        end
      end
      KIND_READ: begin
        marks_nxt = marks_r | MARK_READ;
      end
      KIND_WRITE: begin
        unique case (phase_r)
          PH_IDLE: begin
            timer_nxt = '0;
            if (item.select_bits == SEL_BOTH_LOW) begin
              phase_nxt = PH_SYNC;
              timer_nxt = timeout_ticks;
            end else if (item.select_bits == SEL_BOTH_HIGH) begin
              // Advance the player rotation once all three marks were seen
              if (multi_r) begin
                if (marks_r == MARKS_ALL) begin
                  marks_nxt  = '0;
                  player_nxt = dec;
                  if (four_r ? (dec == PLAYER_WRAP4) : (dec == PLAYER_WRAP2)) begin
                    player_nxt = PLAYER_ONE;
                  end
                end else begin
                  marks_nxt = marks_r & (MARK_P14_LOW | MARK_P15_LOW);
                end
              end
            end else if (item.select_bits == SEL_P14_HIGH) begin
              marks_nxt = marks_r | MARK_P14_LOW;
            end else begin
              marks_nxt = marks_r | MARK_P15_LOW;
            end
          end
          PH_SYNC: begin
            if (item.select_bits == SEL_BOTH_HIGH) begin
              phase_nxt     = PH_XFER;
              byte_pos_nxt  = '0;
              bit_count_nxt = '0;
              timer_nxt     = timeout_ticks;
            end else if (item.select_bits == SEL_BOTH_LOW) begin
              timer_nxt = timeout_ticks;
            end else begin
              phase_nxt = PH_IDLE;
              timer_nxt = '0;
            end
          end
          PH_XFER: begin
            marks_nxt = '0;
            if (item.select_bits == SEL_BOTH_LOW) begin
              phase_nxt = PH_SYNC;
              timer_nxt = '0;
            end else if (item.select_bits == SEL_BOTH_HIGH) begin
              if (bit_count_r >= FULL_BITS) begin
                // Close the packet
                bit_count_nxt      = '0;
                byte_pos_nxt       = '0;
                pkt_cnt_nxt        = (pkt_cnt_r < PKT_CNT_MAX) ? pkt_cnt_r + 3'd1 : pkt_cnt_r;
                timer_nxt          = '0;
                result.packet_done = 1'b1;
                if (pkt_cnt_nxt == header_r[2:0]) begin
                  result.command_done = 1'b1;
                  code_set            = 1'b1;
                  if (header_r[7:3] == CMD_MLT_REQ) begin
                    if (first_data_r[0]) begin
                      multi_nxt = 1'b1;
                      four_nxt  = first_data_r[1];
                      if (first_use_r) begin
                        first_use_nxt = 1'b0;
                        player_nxt    = PLAYER_FIRST;
                      end else begin
                        player_nxt = PLAYER_ONE;
                      end
                    end else begin
                      four_nxt   = 1'b0;
                      multi_nxt  = 1'b0;
                      player_nxt = PLAYER_ONE;
                    end
                  end
                  header_nxt     = '0;
                  first_data_nxt = '0;
                  pkt_cnt_nxt    = '0;
                  phase_nxt      = PH_IDLE;
                end
              end else begin
                // Latch the pending bit, LSB first
                shift_nxt     = {pending_r, shift_r[7:1]};
                bit_count_nxt = bit_count_r + 1'b1;
                if (bit_count_nxt[2:0] == 3'd0) begin
                  result.byte_valid    = 1'b1;
                  result.byte_value    = shift_nxt;
                  result.packet_number = pkt_cnt_r;
                  result.byte_number   = byte_pos_r;
                  if (pkt_cnt_r == 3'd0 && byte_pos_r == 4'd0) header_nxt = shift_nxt;
                  if (pkt_cnt_r == 3'd0 && byte_pos_r == 4'd1) first_data_nxt = shift_nxt;
                  byte_pos_nxt = byte_pos_r + 4'd1;
                end
                timer_nxt = timeout_ticks;
              end
            end else begin
              pending_nxt = (item.select_bits == SEL_P14_LOW) ? 1'b0 : 1'b1;
              timer_nxt   = timeout_ticks;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
          end
        endcase
      end
      default: ;
    endcase

    result.command_code = code_set ? done_code : header_nxt[7:3];
    result.player_id    = player_nxt;
  end

  // Hold state; advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pending_r    <= 1'b0;
      bit_count_r  <= '0;
      shift_r      <= '0;
      byte_pos_r   <= '0;
      pkt_cnt_r    <= '0;
      header_r     <= '0;
      first_data_r <= '0;
      marks_r      <= '0;
      player_r     <= PLAYER_ONE;
      multi_r      <= 1'b0;
      four_r       <= 1'b0;
      first_use_r  <= 1'b1;
      timer_r      <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      pending_r    <= pending_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      byte_pos_r   <= byte_pos_nxt;
      pkt_cnt_r    <= pkt_cnt_nxt;
      header_r     <= header_nxt;
      first_data_r <= first_data_nxt;
      marks_r      <= marks_nxt;
      player_r     <= player_nxt;
      multi_r      <= multi_nxt;
      four_r       <= four_nxt;
      first_use_r  <= first_use_nxt;
      timer_r      <= timer_nxt;
    end
  end

endmodule

>>> hdl/joypad_port_packet_receiver.sv
`timescale 1ns / 1ps
// Joypad port packet receiver: result valid in the cycle after item acceptance.
// Throughput one item per cycle as in_ready follows out_ready; the receiver state
// updates in a single pass and the result register frees in the cycle it is taken.
// Synchronous active-low reset: idle, empty output, timeout_ticks = 1000.
// Depends on jpr_pkg and jpr_core.
module joypad_port_packet_receiver import jpr_pkg::*; #(
  parameter int PACKET_BITS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        accept;
  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   result;
  logic [15:0] timeout_r;

  // Take an item whenever the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  jpr_core #(
    .PACKET_BITS(PACKET_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (accept),
    .item         (in_item),
    .timeout_ticks(timeout_r),
    .result       (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_TIMEOUT) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_TIMEOUT) ? {16'd0, timeout_r} : 32'd0;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for joypad_port_packet_receiver: drives port writes, ticks and
// reads, predicts every report in-line and compares it field by field. Needs jpr_pkg.
module testbench;
  import jpr_pkg::*;

  localparam int          PACKET_BITS  = 128;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 150;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          LONG_HOLD    = 80;
  localparam int          SETTLE       = 4;

  typedef enum logic [1:0] {PH_IDLE, PH_SYNC, PH_XFER} rx_phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted receiver state
  logic [15:0] timeout_limit   = TIMEOUT_RST;
  rx_phase_t   rx_phase        = PH_IDLE;
  logic        pending_bit     = 1'b0;
  logic [7:0]  bit_count       = '0;
  logic [7:0]  byte_shift      = '0;
  logic [3:0]  byte_position   = '0;
  logic [2:0]  packet_count    = '0;
  logic [7:0]  header_byte     = '0;
  logic [7:0]  first_data_byte = '0;
  logic [2:0]  read_marks      = '0;
  logic [3:0]  next_player     = PLAYER_ONE;
  logic        multi_on        = 1'b0;
  logic        four_on         = 1'b0;
  logic        first_use       = 1'b1;
  logic [15:0] port_timer      = '0;

  out_item_t joypad_reports[$];
  int        failures = 0;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  int        hold_request = 0;
  bit        sender_idles = 1'b1;
  bit        receiver_stalls = 1'b1;

  joypad_port_packet_receiver #(.PACKET_BITS(PACKET_BITS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Advance the receiver by one item and return the report it makes
  function automatic out_item_t predict_joypad_step(in_item_t item);
    out_item_t r;
    logic      code_taken;
    r = '0;
    code_taken = 1'b0;
    if (item.kind == KIND_TICK) begin
      if (port_timer != 16'd0) begin
        port_timer = port_timer - 16'd1;
        if (port_timer == 16'd0) begin
          rx_phase = PH_IDLE;
          r.timed_out = 1'b1;
        end
      end
    end else if (item.kind == KIND_READ) begin
      read_marks |= MARK_READ;
    end else if (item.kind == KIND_WRITE) begin
      case (rx_phase)
        PH_IDLE: begin
          if (item.select_bits == SEL_BOTH_LOW) begin
            rx_phase = PH_SYNC;
            port_timer = timeout_limit;
          end else if (item.select_bits == SEL_BOTH_HIGH) begin
            // end of a controller poll: rotate the player id once all lines were seen
            if (multi_on) begin
              if (read_marks == MARKS_ALL) begin
                read_marks = '0;
                next_player = next_player - 4'd1;
                if (four_on && next_player == PLAYER_WRAP4) next_player = PLAYER_ONE;
                if (!four_on && next_player == PLAYER_WRAP2) next_player = PLAYER_ONE;
              end else begin
                read_marks &= ~MARK_READ;
              end
            end
            port_timer = '0;
          end else begin
            read_marks |= (item.select_bits == SEL_P14_HIGH) ? MARK_P14_LOW : MARK_P15_LOW;
            port_timer = '0;
          end
        end
        PH_SYNC: begin
          if (item.select_bits == SEL_BOTH_HIGH) begin
            rx_phase = PH_XFER;
            byte_position = '0;
            bit_count = '0;
            port_timer = timeout_limit;
          end else if (item.select_bits == SEL_BOTH_LOW) begin
            port_timer = timeout_limit;
          end else begin
            rx_phase = PH_IDLE;
            port_timer = '0;
          end
        end
        PH_XFER: begin
          if (item.select_bits == SEL_BOTH_LOW) begin
            rx_phase = PH_SYNC;
            port_timer = '0;
          end else if (item.select_bits == SEL_BOTH_HIGH) begin
            if (bit_count >= PACKET_BITS) begin
              // closing pulse: count the packet, finish the command on the last one
              bit_count = '0;
              byte_position = '0;
              if (packet_count < PKT_CNT_MAX) packet_count = packet_count + 3'd1;
              port_timer = '0;
              r.packet_done = 1'b1;
              if (packet_count == header_byte[2:0]) begin
                r.command_done = 1'b1;
                r.command_code = header_byte[7:3];
                code_taken = 1'b1;
                if (header_byte[7:3] == CMD_MLT_REQ) begin
                  if (first_data_byte[0]) begin
                    multi_on = 1'b1;
                    four_on = first_data_byte[1];
                    next_player = first_use ? PLAYER_FIRST : PLAYER_ONE;
                    first_use = 1'b0;
                  end else begin
                    multi_on = 1'b0;
                    four_on = 1'b0;
                    next_player = PLAYER_ONE;
                  end
                end
                header_byte = '0;
                first_data_byte = '0;
                packet_count = '0;
                rx_phase = PH_IDLE;
              end
            end else begin
              // latch the pending bit, LSB first
              byte_shift = {pending_bit, byte_shift[7:1]};
              bit_count = bit_count + 8'd1;
              if (bit_count[2:0] == 3'd0) begin
                r.byte_valid = 1'b1;
                r.byte_value = byte_shift;
                r.packet_number = packet_count;
                r.byte_number = byte_position;
                if (packet_count == 3'd0 && byte_position == 4'd0) header_byte = byte_shift;
                if (packet_count == 3'd0 && byte_position == 4'd1) first_data_byte = byte_shift;
                byte_position = byte_position + 4'd1;
              end
              port_timer = timeout_limit;
            end
          end else begin
            pending_bit = (item.select_bits == SEL_P14_HIGH);
            port_timer = timeout_limit;
          end
          read_marks = '0;
        end
        default: begin
          rx_phase = PH_IDLE;
          port_timer = '0;
        end
      endcase
    end
    if (!code_taken) r.command_code = header_byte[7:3];
    r.player_id = next_player;
    return r;
  endfunction

  function automatic string show_report(out_item_t r);
    return $sformatf({"byte_valid=%0d byte=%02h packet=%0d pos=%0d pdone=%0d",
                      " cdone=%0d code=%02h id=%h to=%0d"},
                     r.byte_valid, r.byte_value, r.packet_number, r.byte_number, r.packet_done,
                     r.command_done, r.command_code, r.player_id, r.timed_out);
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Predict accepted items, check accepted reports
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (joypad_reports.size() == 0) begin
          note_failure({"report with no item outstanding: ", show_report(out_item)});
        end else begin
          want = joypad_reports.pop_front();
          bad = "";
          if (out_item.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
          if (out_item.byte_value !== want.byte_value) bad = {bad, " byte_value"};
          if (out_item.packet_number !== want.packet_number) bad = {bad, " packet_number"};
          if (out_item.byte_number !== want.byte_number) bad = {bad, " byte_number"};
          if (out_item.packet_done !== want.packet_done) bad = {bad, " packet_done"};
          if (out_item.command_done !== want.command_done) bad = {bad, " command_done"};
          if (out_item.command_code !== want.command_code) bad = {bad, " command_code"};
          if (out_item.player_id !== want.player_id) bad = {bad, " player_id"};
          if (out_item.timed_out !== want.timed_out) bad = {bad, " timed_out"};
          if (bad != "") begin
            note_failure($sformatf("mismatch in%s: expected %s, got %s", bad,
                                   show_report(want), show_report(out_item)));
          end
        end
        stall_left = receiver_stalls ? $urandom_range(0, 5) : 0;
      end
      if (in_valid && in_ready) joypad_reports.push_back(predict_joypad_step(in_item));
    end
  end

  // Drop out_ready for random stalls and for requested long holds
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [1:0] data_select(logic value);
    return value ? SEL_P14_HIGH : SEL_P14_LOW;
  endfunction

  // Offer one item after a random gap when sender_idles is set and hold it until accepted
  task automatic send_item(logic [1:0] kind, logic [1:0] sel);
    int gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{kind: kind, select_bits: sel};
    if (kind != KIND_UNUSED) items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every report is in
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (joypad_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(logic [15:0] ticks);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_TIMEOUT;
    cfg_pwdata <= {16'h0000, ticks};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    timeout_limit = ticks;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(KIND_TICK, 2'($urandom));
      1: send_item(KIND_READ, 2'($urandom));
      2: send_item(KIND_UNUSED, 2'($urandom));
      default: send_item(KIND_WRITE, data_select($urandom_range(0, 1)));
    endcase
  endtask

  // Open pulse, PACKET_BITS data bits LSB first, closing pulse
  task automatic send_packet(logic [127:0] payload, bit noisy);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    for (int i = 0; i < PACKET_BITS; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_noise();
      send_item(KIND_WRITE, data_select(payload[i]));
      send_item(KIND_WRITE, SEL_BOTH_HIGH);
    end
    // a stray data write after the last bit must not be taken
    if ($urandom_range(0, 3) == 0) send_item(KIND_WRITE, data_select($urandom_range(0, 1)));
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
  endtask

  task automatic send_command(logic [7:0] header, logic [7:0] arg, int packets, bit noisy);
    logic [127:0] payload;
    for (int p = 0; p < packets; p++) begin
      payload = {$urandom, $urandom, $urandom, $urandom};
      if (p == 0) payload[15:0] = {arg, header};
      send_packet(payload, noisy);
    end
  endtask

  // One controller poll that sees both lines and a read
  task automatic poll_joypad();
    send_item(KIND_WRITE, SEL_P14_HIGH);
    send_item(KIND_READ, 2'($urandom));
    send_item(KIND_WRITE, SEL_P14_LOW);
    send_item(KIND_READ, 2'($urandom));
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
  endtask

  task automatic test_directed();
    send_item(KIND_TICK, SEL_BOTH_LOW);
    send_item(KIND_READ, SEL_BOTH_HIGH);
    send_item(KIND_UNUSED, SEL_BOTH_HIGH);
    send_item(KIND_UNUSED, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_P14_HIGH);
    send_item(KIND_WRITE, SEL_P14_LOW);
    send_item(KIND_READ, SEL_P14_HIGH);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    // open then drop back to idle on a single line
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_P14_HIGH);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_P14_LOW);
    // enter transfer, latch one bit, reopen, abort
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    send_item(KIND_WRITE, SEL_P14_HIGH);
    send_item(KIND_TICK, SEL_P14_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    send_item(KIND_READ, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_P14_LOW);
    drain();
  endtask

  task automatic test_timeout();
    // one tick expires an open transfer at once
    set_timeout(16'd1);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_TICK, SEL_BOTH_LOW);
    send_item(KIND_TICK, SEL_BOTH_HIGH);
    // expire in the middle of a packet
    set_timeout(16'd3);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    send_item(KIND_WRITE, SEL_P14_LOW);
    repeat (4) send_item(KIND_TICK, 2'($urandom));
    // zero leaves the timer disarmed
    set_timeout(16'd0);
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    repeat (3) send_item(KIND_TICK, 2'($urandom));
    send_item(KIND_WRITE, SEL_BOTH_LOW);
    send_item(KIND_WRITE, SEL_P14_HIGH);
    drain();
  endtask

  task automatic test_multiplayer();
    set_timeout(16'hFFFF);
    // four players; first enable starts at player two's id
    send_command({CMD_MLT_REQ, 3'd1}, 8'h03, 1, 1'b1);
    repeat (5) poll_joypad();
    // poll without a read: no rotation
    send_item(KIND_WRITE, SEL_P14_HIGH);
    send_item(KIND_WRITE, SEL_P14_LOW);
    send_item(KIND_WRITE, SEL_BOTH_HIGH);
    // two players, later enable starts at player one
    send_command({CMD_MLT_REQ, 3'd1}, 8'h01, 1, 1'b0);
    repeat (4) poll_joypad();
    // disable
    send_command({CMD_MLT_REQ, 3'd1}, 8'h00, 1, 1'b0);
    repeat (2) poll_joypad();
    drain();
  endtask

  task automatic test_backpressure();
    // hold the output while the sender keeps offering back to back
    sender_idles = 1'b0;
    hold_request = LONG_HOLD;
    repeat (40) send_item(2'($urandom), 2'($urandom));
    drain();
    repeat (10) send_item(2'($urandom), 2'($urandom));
    drain();
    sender_idles = 1'b1;
  endtask

  task automatic test_random();
    int          start;
    int          pick;
    logic [7:0]  header;
    start = items_sent;
    set_timeout(TIMEOUT_RST);
    while (items_sent - start < RANDOM_ITEMS) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        header = {5'($urandom), 3'($urandom_range(1, 2))};
        if (pick == 0) header[7:3] = CMD_MLT_REQ;
        send_command(header, 8'($urandom), int'(header[2:0]), 1'b1);
      end else if (pick < 7) begin
        // broken packet: up to 40 bits, then timeout or reopen and drop
        send_item(KIND_WRITE, SEL_BOTH_LOW);
        send_item(KIND_WRITE, SEL_BOTH_HIGH);
        repeat ($urandom_range(0, 40)) begin
          send_item(KIND_WRITE, data_select($urandom_range(0, 1)));
          send_item(KIND_WRITE, SEL_BOTH_HIGH);
        end
        if (timeout_limit != 16'd0 && timeout_limit <= 16'd64) begin
          repeat (int'(timeout_limit)) send_item(KIND_TICK, 2'($urandom));
        end else begin
          send_item(KIND_WRITE, SEL_BOTH_LOW);
          send_item(KIND_WRITE, data_select($urandom_range(0, 1)));
        end
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 12)) send_item(2'($urandom), 2'($urandom));
      end else begin
        case ($urandom_range(0, 4))
          0: set_timeout(16'($urandom_range(4, 40)));
          1: set_timeout(TIMEOUT_RST);
          2: set_timeout(16'hFFFF);
          3: set_timeout(16'd0);
          default: set_timeout(16'($urandom_range(41, 5000)));
        endcase
      end
    end
    drain();
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // A zero packet count never completes the command
  task automatic test_zero_count();
    send_command({5'($urandom), 3'd0}, 8'($urandom), 1, 1'b0);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_TIMEOUT;
    cfg_pwdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_timeout();
    test_multiplayer();
    test_backpressure();
    test_random();
    test_zero_count();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (joypad_reports.size() != 0) begin
      note_failure($sformatf("%0d reports never arrived", joypad_reports.size()));
    end
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
